// File: rtl/tga_pkg.sv
`timescale 1ns / 1ps
package tga_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_PALETTE,
        PH_PACKET,
        PH_PIXEL,
        PH_STOP
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    localparam logic [4:0] HDR_LAST = 5'd17;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [14:0] column;
        logic [14:0] dest_row;
        logic [7:0]  run_count;
        logic        top_first;
        logic        image_done;
        logic [2:0]  status;
    } t_res;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [7:0]  quo;
        logic [15:0] rem;
    } t_div_res;

    // color word is {a, b, g, r}
    function automatic logic [31:0] pack_rgba(logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b, logic [7:0] a);
        return {a, b, g, r};
    endfunction

    function automatic logic [7:0] expand5(logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [31:0] from555(logic [7:0] lo, logic [7:0] hi);
        return pack_rgba(expand5(hi[6:2]), expand5({hi[1:0], lo[7:5]}),
                         expand5(lo[4:0]), 8'hFF);
    endfunction

    // bytes per entry for 15/16/24/32 bit, else zero
    function automatic logic [2:0] pal_nbytes(logic [5:0] bits);
        case (bits)
            6'd15, 6'd16: return 3'd2;
            6'd24:        return 3'd3;
            6'd32:        return 3'd4;
            default:      return 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] pix_nbytes(logic [5:0] bits);
        case (bits)
            6'd8:         return 3'd1;
            6'd15, 6'd16: return 3'd2;
            6'd24:        return 3'd3;
            default:      return 3'd4;
        endcase
    endfunction

    // multi-byte color from assembled bytes and the final byte
    function automatic logic [31:0] assemble(logic [2:0] n, logic [23:0] asm_b,
                                             logic [7:0] b);
        case (n)
            3'd2:    return from555(asm_b[7:0], b);
            3'd3:    return pack_rgba(b, asm_b[15:8], asm_b[7:0], 8'hFF);
            default: return pack_rgba(asm_b[23:16], asm_b[15:8], asm_b[7:0], b);
        endcase
    endfunction

endpackage

// File: rtl/tga_div.sv
`timescale 1ns / 1ps
module tga_div
    import tga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dividend,
    input  logic [15:0] i_divisor,
    output t_div_res    o_res
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_k;
    logic [16:0] r_rem;
    logic [7:0]  r_quo;
    logic [15:0] r_dvs;
    logic [23:0] shifted;
    logic        fits;

    assign shifted = {8'd0, r_dvs} << r_k;
    assign fits    = {7'd0, r_rem} >= shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 3'd7;
                r_rem  <= i_dividend;
                r_quo  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem        <= r_rem - shifted[16:0];
                    r_quo[r_k]   <= 1'b1;
                end
                r_k <= r_k - 3'd1;
                if (r_k == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.busy = r_busy | r_done;
    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem[15:0];

endmodule

// File: rtl/tga_image_stream_decoder_top.sv
`timescale 1ns / 1ps
// tga image stream decoder
// input channel: one file byte per item (i_op = 0) or end of file (i_op = 1),
// qualified by i_in_valid, held off by o_in_stall
// output channel: one color run per result on o_out_valid, held by i_out_stall;
// the consumer expands run_count pixels in file scan order starting at
// (column, dest_row)
// a result is valid once its last byte has passed the input register (with
// palette read) and then the result register
// throughput: one byte per cycle when not stalled; a run packet that wraps
// past more than one row runs the cursor divider, which holds the input until done
// a two-entry output buffer lets input continue while one result waits;
// the output side stalls input only when both entries are full
// reset clears the parser to the header phase; palette contents are not
// cleared, only entries loaded for the current image are read
// after an error, truncation or image completion all input is ignored
// until the next reset
module tga_image_stream_decoder_top
    import tga_pkg::*;
#(
    parameter int MAX_SIDE        = 32768,
    parameter int MAX_PIXELS      = 67108864,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_byte_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [14:0] o_column,
    output logic [14:0] o_dest_row,
    output logic [7:0]  o_run_count,
    output logic        o_top_first,
    output logic        o_image_done,
    output logic [2:0]  o_status
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [16:0] SIDE_LIM = 17'(MAX_SIDE);
    localparam logic [32:0] PIX_LIM  = 33'(MAX_PIXELS);
    localparam logic [16:0] PAL_LIM  = 17'(PALETTE_ENTRIES);

    logic [31:0] r_mem [2**AW];

    // input stage
    logic        r_in_v;
    logic        r_in_op;
    logic [7:0]  r_in_b;
    logic [31:0] r_pal_q;

    // state
    t_phase      r_phase, n_phase;
    logic [15:0] r_cnt, n_cnt;
    logic [3:0]  r_kind, n_kind;
    logic [5:0]  r_bpp, n_bpp;
    logic [7:0]  r_idlen, n_idlen;
    logic [15:0] r_pal_len, n_pal_len;
    logic [5:0]  r_pal_bits, n_pal_bits;
    logic [15:0] r_w, n_w;
    logic [15:0] r_h, n_h;
    logic [7:0]  r_desc, n_desc;
    logic [23:0] r_asm, n_asm;
    logic [1:0]  r_item, n_item;
    logic [15:0] r_x, n_x;
    logic [15:0] r_y, n_y;
    logic [7:0]  r_pk_left, n_pk_left;
    logic        r_pk_run, n_pk_run;
    logic [31:0] r_area;
    logic [30:0] r_left, n_left;

    // output buffer
    t_res        r_out, r_skid, res;
    logic        r_out_v, r_skid_v, res_v;

    logic        in_acc, b_go, out_take;
    logic        mem_we;
    logic [31:0] mem_wd;
    logic        div_start;
    logic [16:0] div_t;
    t_div_res    div;

    // combinational helpers
    logic [2:0]  pn, xn;
    logic        pal_kind, raw_kind, last_byte;
    logic [31:0] color;
    logic [7:0]  run_n;
    logic [16:0] adv;
    logic [15:0] row_f;

    assign b_go       = r_in_v & ~r_skid_v & ~div.busy;
    assign o_in_stall = div.busy | (r_in_v & ~b_go);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign out_take   = r_out_v & ~i_out_stall;

    tga_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_t),
        .i_divisor  (r_w),
        .o_res      (div)
    );

    // palette store, with bypass for a write to the address being read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[AW-1:0]] <= mem_wd;
        end
        if (in_acc) begin
            if (mem_we && (r_cnt[AW-1:0] == i_byte_value[AW-1:0])) begin
                r_pal_q <= mem_wd;
            end else begin
                r_pal_q <= r_mem[i_byte_value[AW-1:0]];
            end
            r_in_op <= i_op;
            r_in_b  <= i_byte_value;
        end
    end

    assign pn       = pal_nbytes(r_pal_bits);
    assign xn       = pix_nbytes(r_bpp);
    assign pal_kind = (r_kind == 4'd1) || (r_kind == 4'd9);
    assign raw_kind = (r_kind >= 4'd1) && (r_kind <= 4'd3);

    always_comb begin
        n_phase = r_phase;   n_cnt = r_cnt;       n_kind = r_kind;
        n_bpp = r_bpp;       n_idlen = r_idlen;   n_pal_len = r_pal_len;
        n_pal_bits = r_pal_bits;                  n_w = r_w;
        n_h = r_h;           n_desc = r_desc;     n_asm = r_asm;
        n_item = r_item;     n_x = r_x;           n_y = r_y;
        n_pk_left = r_pk_left;                    n_pk_run = r_pk_run;
        n_left = r_left;
        res = '0;            res_v = 1'b0;
        mem_we = 1'b0;       mem_wd = assemble(pn, r_asm, r_in_b);
        div_start = 1'b0;    div_t = '0;
        color = '0;          run_n = 8'd1;        adv = '0;
        row_f = '0;          last_byte = 1'b0;
        if (b_go && r_phase != PH_STOP) begin
            if (r_in_op) begin
                res_v = 1'b1;
                res.status = ST_TRUNC;
                n_phase = PH_STOP;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        case (r_cnt[4:0])
                            5'd0:  n_idlen = r_in_b;
                            5'd2:  n_kind = (r_in_b > 8'd15) ? 4'd15 : r_in_b[3:0];
                            5'd5:  n_pal_len[7:0] = r_in_b;
                            5'd6:  n_pal_len[15:8] = r_in_b;
                            5'd7:  n_pal_bits = (r_in_b > 8'd63) ? 6'd63 : r_in_b[5:0];
                            5'd12: n_w[7:0] = r_in_b;
                            5'd13: n_w[15:8] = r_in_b;
                            5'd14: n_h[7:0] = r_in_b;
                            5'd15: n_h[15:8] = r_in_b;
                            5'd16: n_bpp = (r_in_b > 8'd63) ? 6'd63 : r_in_b[5:0];
                            5'd17: n_desc = r_in_b;
                            default: ;
                        endcase
                        n_cnt = r_cnt + 16'd1;
                        if (r_cnt[4:0] == HDR_LAST) begin
                            n_left = r_area[30:0];
                            if (!(r_kind <= 4'd3 || (r_kind >= 4'd9 && r_kind <= 4'd11))) begin
                                res_v = 1'b1; res.status = ST_BAD_TYPE; n_phase = PH_STOP;
                            end else if (!(r_bpp == 6'd8 || r_bpp == 6'd15 ||
                                           r_bpp == 6'd16 || r_bpp == 6'd24 ||
                                           r_bpp == 6'd32)) begin
                                res_v = 1'b1; res.status = ST_BAD_DEPTH; n_phase = PH_STOP;
                            end else if (r_w == 16'd0 || r_h == 16'd0 ||
                                         {1'b0, r_w} > SIDE_LIM ||
                                         {1'b0, r_h} > SIDE_LIM ||
                                         {1'b0, r_area} > PIX_LIM) begin
                                res_v = 1'b1; res.status = ST_BAD_SIZE; n_phase = PH_STOP;
                            end else if (r_idlen != 8'd0) begin
                                n_phase = PH_ID;
                            end else begin
                                last_byte = 1'b1;
                            end
                        end
                    end
                    PH_ID: begin
                        n_idlen = r_idlen - 8'd1;
                        if (r_idlen == 8'd1) begin
                            last_byte = 1'b1;
                        end
                    end
                    PH_PALETTE: begin
                        if ({1'b0, r_item} + 3'd1 < pn) begin
                            n_asm  = r_asm | (24'(r_in_b) << {r_item, 3'b000});
                            n_item = r_item + 2'd1;
                        end else begin
                            mem_we = {1'b0, r_cnt} < PAL_LIM;
                            n_item = '0;
                            n_asm  = '0;
                            n_cnt  = r_cnt + 16'd1;
                            if ({1'b0, r_cnt} + 17'd1 >= {1'b0, r_pal_len}) begin
                                n_phase = raw_kind ? PH_PIXEL : PH_PACKET;
                                n_x = '0; n_y = '0; n_pk_left = '0; n_pk_run = 1'b0;
                            end
                        end
                    end
                    PH_PACKET: begin
                        n_pk_left = {1'b0, r_in_b[6:0]} + 8'd1;
                        n_pk_run  = r_in_b[7];
                        n_item    = '0;
                        n_asm     = '0;
                        n_phase   = PH_PIXEL;
                    end
                    PH_PIXEL: begin
                        if ({1'b0, r_item} + 3'd1 < xn) begin
                            n_asm  = r_asm | (24'(r_in_b) << {r_item, 3'b000});
                            n_item = r_item + 2'd1;
                        end else begin
                            if (xn == 3'd1) begin
                                if (pal_kind && r_pal_len != 16'd0) begin
                                    if (pn != 3'd0 && {8'd0, r_in_b} < r_pal_len &&
                                        {9'd0, r_in_b} < PAL_LIM) begin
                                        color = r_pal_q;
                                    end else begin
                                        color = pack_rgba(8'd0, 8'd0, 8'd0, 8'hFF);
                                    end
                                end else begin
                                    color = pack_rgba(r_in_b, r_in_b, r_in_b, 8'hFF);
                                end
                            end else begin
                                color = assemble(xn, r_asm, r_in_b);
                            end
                            n_item = '0;
                            n_asm  = '0;
                            if (!raw_kind && r_pk_run) begin
                                run_n     = r_pk_left;
                                n_pk_left = '0;
                            end else if (r_pk_left != 8'd0) begin
                                n_pk_left = r_pk_left - 8'd1;
                            end
                            // clip the run at the image end
                            if ({23'd0, run_n} > r_left) begin
                                run_n = r_left[7:0];
                            end
                            row_f = r_h - 16'd1 - r_y;
                            res_v = 1'b1;
                            res.red       = color[7:0];
                            res.green     = color[15:8];
                            res.blue      = color[23:16];
                            res.alpha     = color[31:24];
                            res.column    = r_x[14:0];
                            res.dest_row  = r_desc[5] ? r_y[14:0] : row_f[14:0];
                            res.run_count = run_n;
                            res.top_first = r_desc[5];
                            res.image_done = ({23'd0, run_n} == r_left);
                            res.status    = ST_OK;
                            n_left = r_left - {23'd0, run_n};
                            adv = {1'b0, r_x} + {9'd0, run_n};
                            if (res.image_done) begin
                                n_phase = PH_STOP;
                            end else begin
                                if (adv < {1'b0, r_w}) begin
                                    n_x = adv[15:0];
                                end else if (adv < {r_w, 1'b0}) begin
                                    n_x = 16'(adv - {1'b0, r_w});
                                    n_y = r_y + 16'd1;
                                end else begin
                                    // wraps past several rows
                                    div_start = 1'b1;
                                    div_t     = adv;
                                end
                                if (!raw_kind && n_pk_left == 8'd0) begin
                                    n_phase = PH_PACKET;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                // id field done or absent: colour map or pixel data next
                if (last_byte) begin
                    if (pal_kind && r_pal_len != 16'd0 && pn != 3'd0) begin
                        n_phase = PH_PALETTE;
                        n_cnt = '0; n_item = '0; n_asm = '0;
                    end else begin
                        n_phase = raw_kind ? PH_PIXEL : PH_PACKET;
                        n_item = '0; n_asm = '0; n_x = '0; n_y = '0;
                        n_pk_left = '0; n_pk_run = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v     <= 1'b0;
            r_phase    <= PH_HEADER;
            r_cnt      <= '0;  r_kind  <= '0;  r_bpp   <= '0;
            r_idlen    <= '0;  r_pal_len <= '0; r_pal_bits <= '0;
            r_w        <= '0;  r_h     <= '0;  r_desc  <= '0;
            r_asm      <= '0;  r_item  <= '0;  r_x     <= '0;
            r_y        <= '0;  r_pk_left <= '0; r_pk_run <= 1'b0;
            r_left     <= '0;  r_area  <= '0;
            r_out_v    <= 1'b0;
            r_skid_v   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_v <= 1'b1;
            end else if (b_go) begin
                r_in_v <= 1'b0;
            end
            r_phase <= n_phase;  r_cnt <= n_cnt;      r_kind <= n_kind;
            r_bpp <= n_bpp;      r_idlen <= n_idlen;  r_pal_len <= n_pal_len;
            r_pal_bits <= n_pal_bits;                 r_w <= n_w;
            r_h <= n_h;          r_desc <= n_desc;    r_asm <= n_asm;
            r_item <= n_item;    r_pk_left <= n_pk_left;
            r_pk_run <= n_pk_run;                     r_left <= n_left;
            if (div.done) begin
                r_x <= div.rem;
                r_y <= r_y + {8'd0, div.quo};
            end else begin
                r_x <= n_x;
                r_y <= n_y;
            end
            if (r_phase == PH_HEADER) begin
                r_area <= r_w * r_h;
            end
            if (r_skid_v) begin
                if (out_take) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end
            end else if (res_v) begin
                if (!r_out_v || out_take) begin
                    r_out   <= res;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= res;
                    r_skid_v <= 1'b1;
                end
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_red        = r_out.red;
    assign o_green      = r_out.green;
    assign o_blue       = r_out.blue;
    assign o_alpha      = r_out.alpha;
    assign o_column     = r_out.column;
    assign o_dest_row   = r_out.dest_row;
    assign o_run_count  = r_out.run_count;
    assign o_top_first  = r_out.top_first;
    assign o_image_done = r_out.image_done;
    assign o_status     = r_out.status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with empty output register");

    a_error_zero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status != ST_OK) |-> (r_out.run_count == 8'd0))
        else $error("error result carries a run count");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP) |=> (r_phase == PH_STOP))
        else $error("decoder left the stop phase without reset");

    a_div_in_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div.busy |-> (r_phase == PH_PIXEL || r_phase == PH_PACKET))
        else $error("cursor divider busy outside pixel data");

endmodule
